FILE: hdl/assert_macros.svh
// assertion helpers for the rtl files, included by qsp_decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clk edge outside reset
`define QSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qsp assertion failed");

// next-cycle implication, checked at every clk edge outside reset
`define QSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qsp assertion failed");

`endif

FILE: hdl/qsp_pkg.sv
// ----------------------------------------------------------------------------
// qsp_pkg
// shared types, character codes and digit helper for the query string parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qsp_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CASE_MASK = 8'hDF;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_value;
    logic       is_pair_end;
    logic       pair_kept;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } item_beat_t;

  // digit value with no hex check, mod 256
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= CH_UPA) begin
      return (c & CASE_MASK) - CH_UPA + HEX_TEN;
    end
    return c - CH_ZERO;
  endfunction

endpackage

FILE: hdl/qsp_in_if.sv
// ----------------------------------------------------------------------------
// qsp_in_if
// input channel: one query string byte or end marker per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qsp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink (input valid, input op, input in_byte, output ready);
endinterface

FILE: hdl/qsp_out_if.sv
// ----------------------------------------------------------------------------
// qsp_out_if
// output channel: one decoded byte or pair end per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_value;
  logic       is_pair_end;
  logic       pair_kept;

  modport source (output valid, output out_byte, output is_value,
                  output is_pair_end, output pair_kept, input ready);
  modport sink (input valid, input out_byte, input is_value,
                input is_pair_end, input pair_kept, output ready);
endinterface

FILE: hdl/qsp_in_stage.sv
// ----------------------------------------------------------------------------
// qsp_in_stage
// input register; takes a new beat whenever empty or being drained
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsp_in_stage import qsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qsp_in_if.sink      in_ch,
  input  logic        take,
  output item_beat_t  beat
);

  logic     valid;
  in_item_t item;

  assign in_ch.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item.op      <= in_ch.op;
      item.in_byte <= in_ch.in_byte;
    end
  end

  assign beat.valid = valid;
  assign beat.item  = item;

endmodule

FILE: hdl/qsp_decoder.sv
// ----------------------------------------------------------------------------
// qsp_decoder
// pair phase tracking, percent decoding and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qsp_decoder import qsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_beat_t  beat,
  output logic        take,
  qsp_out_if.source   out_ch
);

  typedef enum logic [1:0] {PH_KEY, PH_VAL, PH_ESC1, PH_ESC2} phase_t;

  phase_t     phase, phase_next;
  logic [3:0] high_digit, high_digit_next;
  logic       out_valid;
  out_item_t  out_item;
  out_item_t  res;
  logic       emit;
  logic [7:0] c;
  logic [7:0] dig;
  logic       is_end;
  logic       sep;

  assign c      = beat.item.in_byte;
  assign dig    = digit_of(c);
  assign is_end = beat.item.op || (c == 8'h00);
  assign sep    = is_end || (c == CH_AMP);
  assign take   = beat.valid && (!out_valid || out_ch.ready);

  always_comb begin
    phase_next      = phase;
    high_digit_next = high_digit;
    emit            = 1'b0;
    res             = '0;
    if (sep) begin
      res.is_pair_end = 1'b1;
      res.pair_kept   = (phase != PH_KEY);
      phase_next      = PH_KEY;
      emit            = 1'b1;
    end else begin
      unique case (phase)
        PH_KEY: begin
          if (c == CH_EQ) begin
            phase_next = PH_VAL;
          end else begin
            res.out_byte = c;
            emit         = 1'b1;
          end
        end
        PH_VAL: begin
          if (c == CH_PCT) begin
            phase_next = PH_ESC1;
          end else begin
            res.out_byte = (c == CH_PLUS) ? CH_SPACE : c;
            res.is_value = 1'b1;
            emit         = 1'b1;
          end
        end
        PH_ESC1: begin
          high_digit_next = dig[3:0];
          phase_next      = PH_ESC2;
        end
        PH_ESC2: begin
          res.out_byte = {high_digit, 4'h0} + dig;
          res.is_value = 1'b1;
          emit         = 1'b1;
          phase_next   = PH_VAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_KEY;
      high_digit <= 4'h0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        phase      <= phase_next;
        high_digit <= high_digit_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
        out_item  <= res;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_item.out_byte;
  assign out_ch.is_value    = out_item.is_value;
  assign out_ch.is_pair_end = out_item.is_pair_end;
  assign out_ch.pair_kept   = out_item.pair_kept;

  `QSP_ASSERT_IMPL(a_pair_end_clean, out_valid && out_item.is_pair_end,
                   out_item.out_byte == 8'h00 && !out_item.is_value)
  `QSP_ASSERT_NEXT(a_sep_to_key, take && sep, phase == PH_KEY)
  `QSP_ASSERT_IMPL(a_no_take_when_blocked, out_valid && !out_ch.ready, !take)

endmodule

FILE: hdl/query_string_pair_parser_core.sv
// ----------------------------------------------------------------------------
// query_string_pair_parser_core
// splits a query string into key and value bytes with percent decoding
// ----------------------------------------------------------------------------
// in_ch carries one beat per string character (op = 0) or an end marker
// (op = 1); a zero byte also ends the string. out_ch carries one beat per
// key byte, decoded value byte or pair end. the '=' that ends a key, the
// '%' and the first escape digit produce no output beat.
// an accepted input beat passes through the input register and then the
// decode and result register before its output beat appears.
// throughput is one beat per cycle while the receiver does not stall.
// when the receiver stalls, the result register holds its beat and the
// input register takes one more beat if it is empty before in_ch.ready drops.
// a synchronous reset empties both registers and returns to the key phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module query_string_pair_parser_core import qsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qsp_in_if.sink      in_ch,
  qsp_out_if.source   out_ch
);

  item_beat_t beat;
  logic       take;

  qsp_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .take  (take),
    .beat  (beat)
  );

  qsp_decoder u_decoder (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule
